FILE: design/z80ld_pkg.sv
// ============================================================================
// z80ld_pkg
// Shared types, opcode constants and decode functions for the Z80 length
// predecoder.
// ============================================================================
package z80ld_pkg;

    localparam int AddrWidth = 16;
    localparam int ByteWidth = 8;
    localparam int LenWidth  = 3;

    // Prefix and opcode codes
    localparam logic [7:0] OP_PREFIX_IX = 8'hDD;
    localparam logic [7:0] OP_PREFIX_IY = 8'hFD;
    localparam logic [7:0] OP_PREFIX_CB = 8'hCB;
    localparam logic [7:0] OP_PREFIX_ED = 8'hED;
    localparam logic [7:0] OP_HALT      = 8'h76;
    localparam logic [7:0] OP_DJNZ      = 8'h10;
    localparam logic [7:0] OP_JP_NN     = 8'hC3;
    localparam logic [7:0] OP_CALL_NN   = 8'hCD;
    localparam logic [7:0] OP_OUT_N     = 8'hD3;
    localparam logic [7:0] OP_IN_N      = 8'hDB;
    localparam logic [7:0] OP_EX_SP_HL  = 8'hE3;
    localparam logic [7:0] OP_JP_HL     = 8'hE9;
    localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;

    // ED page codes
    localparam logic [7:0] ED_PAGE_LO    = 8'h40;
    localparam logic [7:0] ED_BLOCK_MASK = 8'hE4;
    localparam logic [7:0] ED_BLOCK_CODE = 8'hA0;
    localparam logic [7:0] ED_IN_F_C     = 8'h70;
    localparam logic [7:0] ED_OUT_C_0    = 8'h71;
    localparam logic [7:0] ED_NEG        = 8'h44;
    localparam logic [7:0] ED_RETI       = 8'h4D;
    localparam logic [7:0] ED_IM_ALIAS   = 8'h4E;
    localparam logic [7:0] ED_IM_2       = 8'h5E;
    localparam logic [7:0] ED_LD_I_A     = 8'h47;
    localparam logic [7:0] ED_LD_R_A     = 8'h4F;
    localparam logic [7:0] ED_LD_A_I     = 8'h57;
    localparam logic [7:0] ED_LD_A_R     = 8'h5F;
    localparam logic [7:0] ED_RRD        = 8'h67;
    localparam logic [7:0] ED_RLD        = 8'h6F;

    // Register operand codes
    localparam logic [2:0] REG_H      = 3'd4;
    localparam logic [2:0] REG_MEM_HL = 3'd6;
    localparam logic [2:0] REG_A      = 3'd7;
    localparam logic [1:0] PAIR_HL    = 2'd2;
    localparam logic [1:0] PAIR_SP    = 2'd3;

    typedef struct packed {
        logic [LenWidth-1:0] len;
        logic                undoc;
        logic                ixused;
        logic                ofsused;
        logic                tvalid;
        logic                rel;      // target is relative, else absolute
    } dec_t;

    function automatic dec_t use_reg(logic [2:0] r, logic half, logic ix, dec_t d);
        dec_t o;
        o = d;
        if (ix && (r >= REG_H) && (r != REG_A)) begin
            if (r == REG_MEM_HL) begin
                o.ixused  = 1'b1;
                o.ofsused = 1'b1;
            end else if (half) begin
                o.ixused = 1'b1;
                o.undoc  = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic dec_t use_pair(logic [7:0] op, logic ix, dec_t d);
        dec_t o;
        o = d;
        if (ix && (op[5:4] == PAIR_HL)) begin
            o.ixused = 1'b1;
        end
        return o;
    endfunction

    function automatic dec_t decode_ed(logic [7:0] x, dec_t d);
        dec_t o;
        o = d;
        o.len = LenWidth'(2);
        if (x[7:6] != ED_PAGE_LO[7:6]) begin
            o.undoc = ((x & ED_BLOCK_MASK) != ED_BLOCK_CODE);
        end else begin
            case (x[2:0])
                3'd0: o.undoc = (x == ED_IN_F_C);
                3'd1: o.undoc = (x == ED_OUT_C_0);
                3'd2: o.undoc = 1'b0;
                3'd3: o.len = LenWidth'(4);
                3'd4: o.undoc = (x != ED_NEG);
                3'd5: o.undoc = (x > ED_RETI);
                3'd6: o.undoc = (x == ED_IM_ALIAS) || (x > ED_IM_2);
                default: begin
                    o.undoc = !((x == ED_LD_I_A) || (x == ED_LD_R_A) ||
                                (x == ED_LD_A_I) || (x == ED_LD_A_R) ||
                                (x == ED_RRD)    || (x == ED_RLD));
                end
            endcase
        end
        return o;
    endfunction

    // Decode one opcode; b1/b2 are the bytes that follow it
    function automatic dec_t decode(logic ix, logic [7:0] op, logic [7:0] b1,
                                    logic [7:0] b2);
        dec_t       d;
        logic [2:0] lo;
        logic [2:0] y;
        logic [7:0] c;
        logic       half;
        d      = '0;
        d.len  = LenWidth'(1);
        lo     = op[2:0];
        y      = op[5:3];
        c      = ix ? b2 : b1;
        half   = (y != REG_MEM_HL) && (lo != REG_MEM_HL);
        case (op[7:6])
            2'b00: begin
                if (lo == 3'd0) begin
                    if (op >= OP_DJNZ) begin
                        d.len    = LenWidth'(2);
                        d.tvalid = 1'b1;
                        d.rel    = 1'b1;
                    end
                end else if (lo == 3'd7) begin
                    d = d;
                end else if (lo == 3'd4 || lo == 3'd5) begin
                    d = use_reg(y, 1'b1, ix, d);
                end else if (lo == 3'd6) begin
                    d     = use_reg(y, 1'b1, ix, d);
                    d.len = LenWidth'(2);
                end else begin
                    case (op[3:0])
                        4'd1: begin
                            d     = use_pair(op, ix, d);
                            d.len = LenWidth'(3);
                        end
                        4'd9: d.ixused = ix;
                        4'd2, 4'd10: begin
                            if (op[5:4] == PAIR_HL) begin
                                d     = use_pair(op, ix, d);
                                d.len = LenWidth'(3);
                            end else if (op[5:4] == PAIR_SP) begin
                                d.len = LenWidth'(3);
                            end
                        end
                        default: d = use_pair(op, ix, d);
                    endcase
                end
            end
            2'b01: begin
                if (op != OP_HALT) begin
                    d = use_reg(y, half, ix, d);
                    d = use_reg(lo, half, ix, d);
                end
            end
            2'b10: d = use_reg(lo, 1'b1, ix, d);
            default: begin
                if (lo == 3'd0 || lo == 3'd7) begin
                    d = d;
                end else if (lo == 3'd2 || lo == 3'd4) begin
                    d.len    = LenWidth'(3);
                    d.tvalid = 1'b1;
                end else if (lo == 3'd6) begin
                    d.len = LenWidth'(2);
                end else if (op[3:0] == 4'd1 || op[3:0] == 4'd5) begin
                    d = use_pair(op, ix, d);
                end else begin
                    case (op)
                        OP_JP_NN, OP_CALL_NN: begin
                            d.len    = LenWidth'(3);
                            d.tvalid = 1'b1;
                        end
                        OP_OUT_N, OP_IN_N: d.len = LenWidth'(2);
                        OP_EX_SP_HL, OP_JP_HL, OP_LD_SP_HL: d.ixused = ix;
                        OP_PREFIX_CB: begin
                            d.len = LenWidth'(2);
                            if ((c[7:6] == 2'b00) && (c[5:3] == REG_MEM_HL)) begin
                                d.undoc = 1'b1;
                            end
                            if (ix) begin
                                d.ixused  = 1'b1;
                                d.ofsused = 1'b1;
                                if (c[2:0] != REG_MEM_HL) begin
                                    d.undoc = 1'b1;
                                end
                            end
                        end
                        OP_PREFIX_ED: begin
                            if (ix) begin
                                d.len = LenWidth'(2);
                            end else begin
                                d = decode_ed(b1, d);
                            end
                        end
                        default: d = d;
                    endcase
                end
            end
        endcase
        return d;
    endfunction

endpackage

FILE: design/prefixed_opcode_length_decoder.sv
// ============================================================================
// prefixed_opcode_length_decoder
// Three-stage streaming predecoder for Z80 instruction length and branches.
// ============================================================================
// One transaction in carries an instruction address and the four code bytes
// found there; one transaction out gives the instruction length (1 to 4),
// an undocumented-opcode flag, a flag for a DD/FD prefix that acts as a
// one-byte NOP, and for JR, DJNZ, JP nn and CALL nn (conditional or not)
// a valid branch target. Three register stages separate s_tdata from
// m_tdata: a result shows on m_tvalid once its input has been registered
// by each stage in turn, and a new transaction is taken every cycle unless
// the downstream stalls the pipeline. The stages are: prefix detect
// and opcode window select, opcode decode (the CB/ED/DD/FD rules), then
// length/target assembly including the 16-bit relative-target adder. Each
// stage has its own valid bit and advances when it is empty or the stage
// after it moves, so bubbles squeeze out during a downstream stall and
// nothing is dropped or repeated.
module prefixed_opcode_length_decoder
    import z80ld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: pc_addr[15:0], code0[23:16], code1[31:24], code2[39:32],
    //          code3[47:40]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // m_tdata: instr_len[2:0], undocumented[3], prefix_is_nop[4],
    //          target_valid[5], branch_target[21:6], zero pad[23:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    // ---------------- handshake and stage valids ----------------
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // A stage may load when it is empty or its content moves on
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ---------------- stage 1: prefix detect and window select ----------------
    logic                 ix_next;
    logic [ByteWidth-1:0] op_next, b1_next, b2_next;

    // Under a DD/FD prefix, shift the decode window one byte along
    assign ix_next = (s_tdata[23:16] == OP_PREFIX_IX) || (s_tdata[23:16] == OP_PREFIX_IY);
    assign op_next = ix_next ? s_tdata[31:24] : s_tdata[23:16];
    assign b1_next = ix_next ? s_tdata[39:32] : s_tdata[31:24];
    assign b2_next = ix_next ? s_tdata[47:40] : s_tdata[39:32];

    logic [AddrWidth-1:0] pc1_reg;
    logic                 ix1_reg;
    logic [ByteWidth-1:0] op1_reg, b1_s1_reg, b2_s1_reg;

    always_ff @(posedge aclk) begin
        if (s_tvalid && adv1) begin
            pc1_reg   <= s_tdata[15:0];
            ix1_reg   <= ix_next;
            op1_reg   <= op_next;
            b1_s1_reg <= b1_next;
            b2_s1_reg <= b2_next;
        end
    end

    // ---------------- stage 2: opcode decode ----------------
    dec_t                 dec_next;

    assign dec_next = decode(ix1_reg, op1_reg, b1_s1_reg, b2_s1_reg);

    logic                 ix2_reg;
    dec_t                 dec2_reg;
    logic [AddrWidth-1:0] pc2_reg;
    logic [ByteWidth-1:0] b1_reg, b2_reg;

    always_ff @(posedge aclk) begin
        if (v1_reg && adv2) begin
            ix2_reg  <= ix1_reg;
            dec2_reg <= dec_next;
            pc2_reg  <= pc1_reg;
            b1_reg   <= b1_s1_reg;
            b2_reg   <= b2_s1_reg;
        end
    end

    // ---------------- stage 3: length and target assembly ----------------
    logic [LenWidth-1:0]  len_next;
    logic                 undoc_next, pnop_next, tv_next;
    logic [AddrWidth-1:0] rel_target, tgt_next;

    // Relative targets only matter without a prefix, so pc here is unshifted
    assign rel_target = pc2_reg + AddrWidth'(2)
                      + {{(AddrWidth-ByteWidth){b1_reg[ByteWidth-1]}}, b1_reg};

    always_comb begin
        len_next   = dec2_reg.len;
        undoc_next = dec2_reg.undoc;
        pnop_next  = 1'b0;
        tv_next    = 1'b0;
        tgt_next   = '0;
        if (ix2_reg) begin
            if (!dec2_reg.ixused) begin
                // Prefix had no effect: report a one-byte undocumented NOP
                len_next   = LenWidth'(1);
                undoc_next = 1'b1;
                pnop_next  = 1'b1;
            end else begin
                len_next = LenWidth'(1) + dec2_reg.len
                         + LenWidth'(dec2_reg.ofsused);
            end
        end else if (dec2_reg.tvalid) begin
            tv_next  = 1'b1;
            tgt_next = dec2_reg.rel ? rel_target : {b2_reg, b1_reg};
        end
    end

    logic [LenWidth-1:0]  len_reg;
    logic                 undoc_reg, pnop_reg, tv_reg;
    logic [AddrWidth-1:0] tgt_reg;

    always_ff @(posedge aclk) begin
        if (v2_reg && adv3) begin
            len_reg   <= len_next;
            undoc_reg <= undoc_next;
            pnop_reg  <= pnop_next;
            tv_reg    <= tv_next;
            tgt_reg   <= tgt_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {2'b00, tgt_reg, tv_reg, pnop_reg, undoc_reg, len_reg};

`ifndef NO_ASSERTIONS
    // An ineffective prefix is always a one-byte undocumented NOP
    a_pnop_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && pnop_reg) |-> (len_reg == LenWidth'(1)) && undoc_reg && !tv_reg)
        else $error("prefix NOP result malformed");

    // Length stays within one to four bytes
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (len_reg >= LenWidth'(1)) && (len_reg <= LenWidth'(4)))
        else $error("instruction length out of range");

    // No target is reported without target_valid
    a_tgt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !tv_reg) |-> (tgt_reg == '0))
        else $error("branch target set without target_valid");

    // An accepted transaction occupies stage one on the next cycle
    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transaction lost at stage one");

    // A held result keeps stage three occupied
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !m_tready) |=> v3_reg && $stable(m_tdata))
        else $error("stalled result lost");
`endif

endmodule
